// ===== sv/ahcm_pkg.sv =====
// Shared constants, op and status codes, and channel payload types of the matcher.
package ahcm_pkg;

	localparam int MAX_NODES     = 256;
	localparam int MAX_PATTERNS  = 16;
	localparam int ALPHABET_SIZE = 256;

	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = NODE_W + 1;
	localparam int ALPHA_W    = $clog2(ALPHABET_SIZE);
	localparam int GOTO_DEPTH = MAX_NODES * ALPHABET_SIZE;
	localparam int GOTO_AW    = NODE_W + ALPHA_W;
	localparam int MASK_W     = MAX_PATTERNS;
	localparam int SYM_W      = 8;
	localparam int PID_W      = 4;
	localparam int DEPTH_W    = 9;
	localparam int POS_W      = 32;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;
	localparam int IDX_W      = 8;

	localparam logic [OP_W-1:0] OP_CURSOR_RESET = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK         = 3'd2;
	localparam logic [OP_W-1:0] OP_BUILD        = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH       = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ID_USED = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 9'd511;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SYM_W-1:0] symbol;
		logic [PID_W-1:0] pattern_id;
		logic             text_start;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                match_valid;
		logic [PID_W-1:0]    match_pattern;
		logic [POS_W-1:0]    match_start;
		logic [IDX_W-1:0]    node_index;
		logic                last;
	} rsp_t;

endpackage

// ===== sv/ahcm_req_if.sv =====
// Request channel of the matcher: valid, ready and one command item.
interface ahcm_req_if;
	logic          valid;
	logic          ready;
	ahcm_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ahcm_rsp_if.sv =====
// Result channel of the matcher: valid, ready and one result item.
interface ahcm_rsp_if;
	logic          valid;
	logic          ready;
	ahcm_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/aho_corasick_matcher_unit.sv =====
// Aho-Corasick matcher: trie, failure links and pattern masks kept in single-port-read RAMs.
//
// This block holds a trie of up to 256 nodes over a 256-symbol alphabet in a goto RAM of
// 65536 bytes, plus per-node failure-link and pattern-mask RAMs, a pattern-length RAM and a
// breadth-first work queue RAM. Every RAM has a registered read port and the sequencer
// reads, modifies and writes back one entry at a time, so the block takes one command at a
// time. After reset the block runs a clearing pass over the goto RAM and accepts no command
// until it ends. A cursor reset or an unknown op goes straight to its result; an insert or
// a mark reads its RAM entry first and writes only when it adds a node or a mark. A search
// reads the goto RAM and follows failure links until an edge is found or the root is
// reached, then gives an empty result when no pattern matches and one report per matching
// pattern otherwise. Reports come in ascending id order. A failure build visits every
// symbol of the root and of every queued node, queues each child edge found, chases failure
// links and merges masks. The goto RAM port is what every step of the walk waits on. A
// finished result sits in an output register and the sequencer moves on while it waits for
// its transfer; a stalled result holds the sequencer only when the next result is ready to
// be loaded.
module aho_corasick_matcher_unit (
	input  logic clk,
	input  logic arst_n,
	ahcm_req_if.sink   req,
	ahcm_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RESP,
		S_INS_RD, S_INS_USE, S_MARK_RD, S_MARK_USE,
		S_B0_RD, S_B0_USE, S_BQ_CHK, S_BQ_RD, S_BQ_CUR, S_BQ_FCUR,
		S_BC_RD, S_BC_NX, S_BH_RD, S_BH_USE, S_BF_USE, S_BM1, S_BM2, S_BM3,
		S_S_RD, S_S_USE, S_S_FAIL, S_S_HIT, S_S_MASK, S_E_PICK, S_E_OUT
	} state_t;

	state_t state_q;

	// Memories.
	logic [ahcm_pkg::NODE_W-1:0]  goto_mem  [ahcm_pkg::GOTO_DEPTH];
	logic [ahcm_pkg::NODE_W-1:0]  fail_mem  [ahcm_pkg::MAX_NODES];
	logic [ahcm_pkg::MASK_W-1:0]  mask_mem  [ahcm_pkg::MAX_NODES];
	logic [ahcm_pkg::DEPTH_W-1:0] plen_mem  [ahcm_pkg::MAX_PATTERNS];
	logic [ahcm_pkg::NODE_W-1:0]  queue_mem [ahcm_pkg::MAX_NODES];

	logic [ahcm_pkg::GOTO_AW-1:0] goto_ra, goto_wa;
	logic [ahcm_pkg::NODE_W-1:0]  goto_wd, goto_rd;
	logic                         goto_we;
	logic [ahcm_pkg::NODE_W-1:0]  fail_ra, fail_wa, fail_wd, fail_rd;
	logic                         fail_we;
	logic [ahcm_pkg::NODE_W-1:0]  mask_ra, mask_wa;
	logic [ahcm_pkg::MASK_W-1:0]  mask_wd, mask_rd;
	logic                         mask_we;
	logic [ahcm_pkg::PID_W-1:0]   plen_ra, plen_wa;
	logic [ahcm_pkg::DEPTH_W-1:0] plen_wd, plen_rd;
	logic                         plen_we;
	logic [ahcm_pkg::NODE_W-1:0]  queue_ra, queue_wa, queue_wd, queue_rd;
	logic                         queue_we;

	// Control and working registers.
	logic [ahcm_pkg::GOTO_AW-1:0]  clr_q;
	ahcm_pkg::req_t                cmd_q;
	logic [ahcm_pkg::NODE_W-1:0]   cursor_q, scan_q, cur_q, fcur_q, f_q, nx_q, hit_q;
	logic [ahcm_pkg::DEPTH_W-1:0]  depth_q;
	logic [ahcm_pkg::CNT_W-1:0]    node_cnt_q, head_q, tail_q, guard_q;
	logic [ahcm_pkg::MASK_W-1:0]   id_used_q, rem_q, mh_q;
	logic [ahcm_pkg::POS_W-1:0]    pos_q, spos_q;
	logic [ahcm_pkg::ALPHA_W-1:0]  c_q;
	logic [ahcm_pkg::STATUS_W-1:0] rsp_status_q;
	logic [ahcm_pkg::NODE_W-1:0]   rsp_node_q;
	ahcm_pkg::rsp_t                out_q;
	logic                          out_v_q;

	logic                         out_free;
	logic                         out_load;
	logic [ahcm_pkg::ALPHA_W-1:0] sym;
	logic                         ins_new, mark_ok, chase, c_end, tail_room;
	logic [ahcm_pkg::PID_W-1:0]   pick_idx;
	logic [ahcm_pkg::MASK_W-1:0]  rem_after;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_v_q || rsp.ready;
	// A result is loaded into the output register in this cycle.
	assign out_load  = out_free && ((state_q == S_RESP) || (state_q == S_E_OUT));

	assign sym       = cmd_q.symbol[ahcm_pkg::ALPHA_W-1:0];
	assign ins_new   = (goto_rd == '0) &&
		(node_cnt_q < ahcm_pkg::CNT_W'(ahcm_pkg::MAX_NODES));
	assign mark_ok   = (int'(cmd_q.pattern_id) < ahcm_pkg::MAX_PATTERNS) &&
		!id_used_q[cmd_q.pattern_id];
	assign chase     = (goto_rd == '0) && (f_q != '0) &&
		(guard_q < ahcm_pkg::CNT_W'(ahcm_pkg::MAX_NODES));
	assign c_end     = (c_q == ahcm_pkg::ALPHA_W'(ahcm_pkg::ALPHABET_SIZE - 1));
	assign tail_room = (tail_q < ahcm_pkg::CNT_W'(ahcm_pkg::MAX_NODES));

	// Lowest pattern still to be reported.
	always_comb begin
		pick_idx = '0;
		for (int i = ahcm_pkg::MASK_W - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick_idx = ahcm_pkg::PID_W'(i);
			end
		end
	end
	assign rem_after = rem_q & ~(ahcm_pkg::MASK_W'(1) << pick_idx);

	// Read addresses follow the state; data appears in the following state.
	always_comb begin
		goto_ra = {cursor_q, sym};
		fail_ra = scan_q;
		mask_ra = scan_q;
		case (state_q)
			S_B0_RD:    goto_ra = {ahcm_pkg::NODE_W'(0), c_q};
			S_BC_RD:    goto_ra = {cur_q, c_q};
			S_BH_RD:    goto_ra = {f_q, c_q};
			S_S_RD:     goto_ra = {scan_q, sym};
			S_BQ_CUR:   fail_ra = queue_rd;
			S_BH_USE:   fail_ra = f_q;
			S_MARK_RD:  mask_ra = cursor_q;
			S_BM1:      mask_ra = hit_q;
			S_BM2:      mask_ra = nx_q;
			default:    goto_ra = {cursor_q, sym};
		endcase
		queue_ra = head_q[ahcm_pkg::NODE_W-1:0];
		plen_ra  = pick_idx;
	end

	// Write ports.
	always_comb begin
		goto_we  = 1'b0;
		goto_wa  = clr_q;
		goto_wd  = '0;
		fail_we  = 1'b0;
		fail_wa  = clr_q[ahcm_pkg::NODE_W-1:0];
		fail_wd  = '0;
		mask_we  = 1'b0;
		mask_wa  = clr_q[ahcm_pkg::NODE_W-1:0];
		mask_wd  = '0;
		plen_we  = 1'b0;
		plen_wa  = cmd_q.pattern_id;
		plen_wd  = depth_q;
		queue_we = 1'b0;
		queue_wa = tail_q[ahcm_pkg::NODE_W-1:0];
		queue_wd = goto_rd;
		case (state_q)
			S_CLR: begin
				goto_we = 1'b1;
				fail_we = 1'b1;
				mask_we = 1'b1;
			end
			S_INS_USE: begin
				if (ins_new) begin
					goto_we = 1'b1;
					goto_wa = {cursor_q, sym};
					goto_wd = node_cnt_q[ahcm_pkg::NODE_W-1:0];
					fail_we = 1'b1;
					fail_wa = node_cnt_q[ahcm_pkg::NODE_W-1:0];
					mask_we = 1'b1;
					mask_wa = node_cnt_q[ahcm_pkg::NODE_W-1:0];
				end
			end
			S_MARK_USE: begin
				if (mark_ok) begin
					mask_we = 1'b1;
					mask_wa = cursor_q;
					mask_wd = mask_rd | (ahcm_pkg::MASK_W'(1) << cmd_q.pattern_id);
					plen_we = 1'b1;
				end
			end
			S_B0_USE: begin
				if (goto_rd != '0) begin
					fail_we  = 1'b1;
					fail_wa  = goto_rd;
					queue_we = tail_room;
				end
			end
			S_BC_NX: begin
				queue_we = (goto_rd != '0) && tail_room;
			end
			S_BH_USE: begin
				if (!chase) begin
					fail_we = 1'b1;
					fail_wa = nx_q;
					fail_wd = goto_rd;
				end
			end
			S_BM3: begin
				mask_we = 1'b1;
				mask_wa = nx_q;
				mask_wd = mask_rd | mh_q;
			end
			default: goto_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (goto_we) begin
			goto_mem[goto_wa] <= goto_wd;
		end
		goto_rd <= goto_mem[goto_ra];
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[fail_wa] <= fail_wd;
		end
		fail_rd <= fail_mem[fail_ra];
	end

	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[mask_wa] <= mask_wd;
		end
		mask_rd <= mask_mem[mask_ra];
	end

	always_ff @(posedge clk) begin
		if (plen_we) begin
			plen_mem[plen_wa] <= plen_wd;
		end
		plen_rd <= plen_mem[plen_ra];
	end

	always_ff @(posedge clk) begin
		if (queue_we) begin
			queue_mem[queue_wa] <= queue_wd;
		end
		queue_rd <= queue_mem[queue_ra];
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			cursor_q     <= '0;
			depth_q      <= '0;
			node_cnt_q   <= ahcm_pkg::CNT_W'(1);
			id_used_q    <= '0;
			scan_q       <= '0;
			pos_q        <= '0;
			out_v_q      <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			guard_q      <= '0;
			c_q          <= '0;
			rem_q        <= '0;
			rsp_status_q <= ahcm_pkg::ST_OK;
			rsp_node_q   <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ahcm_pkg::GOTO_AW'(ahcm_pkg::GOTO_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.data;
						rsp_status_q <= ahcm_pkg::ST_OK;
						rsp_node_q   <= '0;
						guard_q      <= '0;
						case (req.data.op)
							ahcm_pkg::OP_CURSOR_RESET: begin
								cursor_q <= '0;
								depth_q  <= '0;
								state_q  <= S_RESP;
							end
							ahcm_pkg::OP_INSERT: state_q <= S_INS_RD;
							ahcm_pkg::OP_MARK:   state_q <= S_MARK_RD;
							ahcm_pkg::OP_BUILD: begin
								c_q     <= '0;
								head_q  <= '0;
								tail_q  <= '0;
								state_q <= S_B0_RD;
							end
							ahcm_pkg::OP_SEARCH: begin
								if (req.data.text_start) begin
									scan_q <= '0;
									spos_q <= '0;
								end else begin
									spos_q <= pos_q;
								end
								state_q <= S_S_RD;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q.status        <= rsp_status_q;
						out_q.match_valid   <= 1'b0;
						out_q.match_pattern <= '0;
						out_q.match_start   <= '0;
						out_q.node_index    <= ahcm_pkg::IDX_W'(rsp_node_q);
						out_q.last          <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_INS_RD: state_q <= S_INS_USE;
				S_INS_USE: begin
					if (goto_rd != '0) begin
						cursor_q   <= goto_rd;
						rsp_node_q <= goto_rd;
						if (depth_q != ahcm_pkg::DEPTH_MAX) begin
							depth_q <= depth_q + 1'b1;
						end
					end else if (ins_new) begin
						cursor_q   <= node_cnt_q[ahcm_pkg::NODE_W-1:0];
						rsp_node_q <= node_cnt_q[ahcm_pkg::NODE_W-1:0];
						node_cnt_q <= node_cnt_q + 1'b1;
						if (depth_q != ahcm_pkg::DEPTH_MAX) begin
							depth_q <= depth_q + 1'b1;
						end
					end else begin
						rsp_status_q <= ahcm_pkg::ST_FULL;
						rsp_node_q   <= cursor_q;
					end
					state_q <= S_RESP;
				end
				S_MARK_RD: state_q <= S_MARK_USE;
				S_MARK_USE: begin
					if (mark_ok) begin
						id_used_q[cmd_q.pattern_id] <= 1'b1;
					end else begin
						rsp_status_q <= ahcm_pkg::ST_ID_USED;
					end
					rsp_node_q <= cursor_q;
					state_q    <= S_RESP;
				end
				S_B0_RD: state_q <= S_B0_USE;
				S_B0_USE: begin
					if ((goto_rd != '0) && tail_room) begin
						tail_q <= tail_q + 1'b1;
					end
					if (c_end) begin
						state_q <= S_BQ_CHK;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_B0_RD;
					end
				end
				S_BQ_CHK: begin
					if (head_q < tail_q) begin
						state_q <= S_BQ_RD;
					end else begin
						rsp_node_q <= cursor_q;
						state_q    <= S_RESP;
					end
				end
				S_BQ_RD: begin
					head_q  <= head_q + 1'b1;
					state_q <= S_BQ_CUR;
				end
				S_BQ_CUR: begin
					cur_q   <= queue_rd;
					state_q <= S_BQ_FCUR;
				end
				S_BQ_FCUR: begin
					fcur_q  <= fail_rd;
					c_q     <= '0;
					state_q <= S_BC_RD;
				end
				S_BC_RD: state_q <= S_BC_NX;
				S_BC_NX: begin
					if (goto_rd == '0) begin
						if (c_end) begin
							state_q <= S_BQ_CHK;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= S_BC_RD;
						end
					end else begin
						nx_q    <= goto_rd;
						f_q     <= fcur_q;
						guard_q <= '0;
						if (tail_room) begin
							tail_q <= tail_q + 1'b1;
						end
						state_q <= S_BH_RD;
					end
				end
				S_BH_RD: state_q <= S_BH_USE;
				S_BH_USE: begin
					if (chase) begin
						state_q <= S_BF_USE;
					end else if (goto_rd != '0) begin
						hit_q   <= goto_rd;
						state_q <= S_BM1;
					end else if (c_end) begin
						state_q <= S_BQ_CHK;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_BC_RD;
					end
				end
				S_BF_USE: begin
					f_q     <= fail_rd;
					guard_q <= guard_q + 1'b1;
					state_q <= S_BH_RD;
				end
				S_BM1: state_q <= S_BM2;
				S_BM2: begin
					mh_q    <= mask_rd;
					state_q <= S_BM3;
				end
				S_BM3: begin
					if (c_end) begin
						state_q <= S_BQ_CHK;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_BC_RD;
					end
				end
				S_S_RD: state_q <= S_S_USE;
				S_S_USE: begin
					if (goto_rd != '0) begin
						scan_q  <= goto_rd;
						state_q <= S_S_HIT;
					end else if ((scan_q == '0) ||
							(guard_q >= ahcm_pkg::CNT_W'(ahcm_pkg::MAX_NODES))) begin
						scan_q  <= '0;
						state_q <= S_S_HIT;
					end else begin
						state_q <= S_S_FAIL;
					end
				end
				S_S_FAIL: begin
					scan_q  <= fail_rd;
					guard_q <= guard_q + 1'b1;
					state_q <= S_S_RD;
				end
				S_S_HIT: begin
					pos_q      <= spos_q + 1'b1;
					rsp_node_q <= scan_q;
					state_q    <= (scan_q == '0) ? S_RESP : S_S_MASK;
				end
				S_S_MASK: begin
					rem_q   <= mask_rd;
					state_q <= (mask_rd == '0) ? S_RESP : S_E_PICK;
				end
				S_E_PICK: state_q <= S_E_OUT;
				S_E_OUT: begin
					if (out_free) begin
						out_q.status        <= ahcm_pkg::ST_OK;
						out_q.match_valid   <= 1'b1;
						out_q.match_pattern <= pick_idx;
						out_q.match_start   <= spos_q - ahcm_pkg::POS_W'(plen_rd) + 1'b1;
						out_q.node_index    <= ahcm_pkg::IDX_W'(scan_q);
						out_q.last          <= (rem_after == '0);
						rem_q               <= rem_after;
						state_q             <= (rem_after == '0) ? S_IDLE : S_E_PICK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The trie never grows past its capacity.
	a_node_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_cnt_q <= ahcm_pkg::CNT_W'(ahcm_pkg::MAX_NODES))
		else $error("node count beyond capacity");

	// The work queue never reads ahead of what was written.
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	// No command is taken while the clearing pass runs.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !req.ready)
		else $error("command taken during clearing pass");

	// One command at a time: after a transfer in, the port closes.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second command taken back to back");

	// A result transfer marked last leaves no reports pending.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E_OUT && out_free && rem_after == '0) |=> (state_q == S_IDLE))
		else $error("search did not finish after its last result");

endmodule
